FILE: sv/piecewise_linear_sample_remap_top_macros.svh
`ifndef PIECEWISE_LINEAR_SAMPLE_REMAP_TOP_MACROS_SVH
`define PIECEWISE_LINEAR_SAMPLE_REMAP_TOP_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define PLSR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on every rising edge out of reset
`define PLSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/plsr_pkg.sv
`timescale 1ns / 1ps

package plsr_pkg;

   // default table depth
   localparam int MAX_POINTS_DEF = 16;

   // field widths
   localparam int PC_W        = 5;
   localparam int TYPE_W      = 3;
   localparam int IDX_W       = 4;
   localparam int PIN_W       = 33;
   localparam int POUT_W      = 50;
   localparam int SLOPE_W     = 50;
   localparam int SAMPLE_W    = 32;
   localparam int X_W         = 33;
   localparam int VALUE_W     = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;

   // words held between front and back
   localparam int QUEUE_DEPTH = 2;

   // interpolation datapath
   localparam int FRAC_W  = 16;
   localparam int SEG_W   = X_W + 1;
   localparam int CHUNK_W = 17;
   localparam int CHUNK_N = 3;
   localparam int PP_W    = SEG_W + CHUNK_W + 1;
   localparam int ACC_W   = 86;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_POINT_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INPUT_TYPE  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTPUT_TYPE = 2'd2;

   // sample type codes
   localparam logic [TYPE_W-1:0] TY_INT32  = 3'd0;
   localparam logic [TYPE_W-1:0] TY_UINT32 = 3'd1;
   localparam logic [TYPE_W-1:0] TY_INT16  = 3'd2;
   localparam logic [TYPE_W-1:0] TY_UINT16 = 3'd3;
   localparam logic [TYPE_W-1:0] TY_BYTE   = 3'd4;

   typedef enum logic [1:0] {
      ITEM_LOAD,
      ITEM_CONVERT,
      ITEM_REJECT
   } item_kind_type;

   typedef enum logic [1:0] {
      OW_32,
      OW_16,
      OW_8
   } out_width_type;

   typedef struct packed {
      item_kind_type               kind;
      logic [IDX_W-1:0]            point_index;
      logic signed [PIN_W-1:0]     point_in;
      logic signed [POUT_W-1:0]    point_out;
      logic signed [SLOPE_W-1:0]   point_slope;
      logic signed [X_W-1:0]       sample_x;
      out_width_type               out_width;
      logic                        last;
   } queue_entry_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_FIRST,
      BK_SCAN,
      BK_FETCH,
      BK_MUL,
      BK_ADD,
      BK_ROUND
   } back_state_type;

endpackage

FILE: sv/plsr_front.sv
`timescale 1ns / 1ps

module plsr_front import plsr_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [CSR_INDEX_W-1:0]              csr_index,
   input  logic [CSR_DATA_W-1:0]               csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_mode,
   input  logic [IDX_W-1:0]                    req_point_index,
   input  logic signed [PIN_W-1:0]             req_point_in,
   input  logic signed [POUT_W-1:0]            req_point_out,
   input  logic signed [SLOPE_W-1:0]           req_point_slope,
   input  logic [SAMPLE_W-1:0]                 req_sample,
   input  logic                                req_last_in,
   output logic                                push_valid,
   input  logic                                push_ready,
   output queue_entry_type                     push_data,
   output logic [$clog2(MAX_POINTS + 1)-1:0]   point_limit
);

   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int CMP_W = (CNT_W > PC_W) ? CNT_W : PC_W;

   logic [PC_W-1:0]   point_count_ff, point_count_in;
   logic [TYPE_W-1:0] input_type_ff, input_type_in;
   logic [TYPE_W-1:0] output_type_ff, output_type_in;
   logic [CMP_W-1:0]  count_wide;
   logic              index_ok;
   logic              pair_ok;
   logic signed [X_W-1:0] sample_x;
   out_width_type     out_width;

   // configuration write decode
   always_comb begin
      point_count_in = point_count_ff;
      input_type_in  = input_type_ff;
      output_type_in = output_type_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_POINT_COUNT: point_count_in = csr_wdata;
            CSR_INPUT_TYPE:  input_type_in  = csr_wdata[TYPE_W-1:0];
            CSR_OUTPUT_TYPE: output_type_in = csr_wdata[TYPE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= PC_W'(1);
         input_type_ff  <= TY_INT32;
         output_type_ff <= TY_INT32;
      end else begin
         point_count_ff <= point_count_in;
         input_type_ff  <= input_type_in;
         output_type_ff <= output_type_in;
      end
   end

   // active point count, clamped to one..table depth
   always_comb begin
      count_wide = CMP_W'(point_count_ff);
      if (count_wide == '0) begin
         point_limit = CNT_W'(1);
      end else if (count_wide > CMP_W'(MAX_POINTS)) begin
         point_limit = CNT_W'(MAX_POINTS);
      end else begin
         point_limit = count_wide[CNT_W-1:0];
      end
   end

   assign index_ok = CMP_W'(req_point_index) < CMP_W'(MAX_POINTS);

   // supported input/output type pairs
   always_comb begin
      case (input_type_ff)
         TY_INT32, TY_UINT32: pair_ok = (output_type_ff <= TY_BYTE);
         TY_INT16, TY_UINT16: pair_ok = (output_type_ff <= TY_BYTE) &&
                                        (output_type_ff >= TY_INT16);
         TY_BYTE:             pair_ok = (output_type_ff == TY_BYTE);
         default:             pair_ok = 1'b0;
      endcase
   end

   // raw sample to integer per input type
   always_comb begin
      case (input_type_ff)
         TY_INT32:  sample_x = {req_sample[31], req_sample};
         TY_UINT32: sample_x = {1'b0, req_sample};
         TY_INT16:  sample_x = {{17{req_sample[15]}}, req_sample[15:0]};
         TY_UINT16: sample_x = {17'd0, req_sample[15:0]};
         default:   sample_x = {25'd0, req_sample[7:0]};
      endcase
   end

   // output width class
   always_comb begin
      if (output_type_ff <= TY_UINT32) begin
         out_width = OW_32;
      end else if (output_type_ff <= TY_UINT16) begin
         out_width = OW_16;
      end else begin
         out_width = OW_8;
      end
   end

   // classify and forward; loads to slots beyond the table are dropped
   always_comb begin
      push_data.kind        = req_mode ? (pair_ok ? ITEM_CONVERT : ITEM_REJECT) : ITEM_LOAD;
      push_data.point_index = req_point_index;
      push_data.point_in    = req_point_in;
      push_data.point_out   = req_point_out;
      push_data.point_slope = req_point_slope;
      push_data.sample_x    = sample_x;
      push_data.out_width   = out_width;
      push_data.last        = req_last_in;
   end

   assign req_ready  = push_ready;
   assign push_valid = req_valid && (req_mode || index_ok);

endmodule

FILE: sv/plsr_queue.sv
`timescale 1ns / 1ps

module plsr_queue import plsr_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   output logic            push_ready,
   input  queue_entry_type push_data,
   output logic            pop_valid,
   input  logic            pop_ready,
   output queue_entry_type pop_data
);

   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   queue_entry_type      entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wptr_ff, wptr_in;
   logic [PTR_W-1:0]     rptr_ff, rptr_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 push_fire;
   logic                 pop_fire;

   assign push_ready = (count_ff != COUNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   // pointer and fill tracking
   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push_fire) begin
         wptr_in = (wptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + PTR_W'(1);
      end
      if (pop_fire) begin
         rptr_in = (rptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + PTR_W'(1);
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // word storage
   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wptr_ff] <= push_data;
      end
   end

endmodule

FILE: sv/plsr_back.sv
`timescale 1ns / 1ps
`include "piecewise_linear_sample_remap_top_macros.svh"

module plsr_back import plsr_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [$clog2(MAX_POINTS + 1)-1:0]   point_limit,
   input  logic                                q_valid,
   output logic                                q_ready,
   input  queue_entry_type                     q_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [VALUE_W-1:0]                  rsp_value,
   output logic                                rsp_status,
   output logic                                rsp_last_out
);

   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int AW     = $clog2(MAX_POINTS);
   localparam int XW     = (AW > IDX_W) ? AW : IDX_W;
   localparam int STEP_W = $clog2(CHUNK_N);

   // breakpoint tables
   logic signed [PIN_W-1:0]   in_tbl_ff    [MAX_POINTS];
   logic signed [POUT_W-1:0]  out_tbl_ff   [MAX_POINTS];
   logic signed [SLOPE_W-1:0] slope_tbl_ff [MAX_POINTS];
   logic signed [PIN_W-1:0]   in_q_ff;
   logic signed [POUT_W-1:0]  out_q_ff;
   logic signed [SLOPE_W-1:0] slope_q_ff;
   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic [AW-1:0]             rd_addr;
   logic [XW-1:0]             idx_wide;

   back_state_type            state_ff, state_in;
   logic [CNT_W-1:0]          idx_ff, idx_in;
   logic [CNT_W:0]            idx_p1, idx_p2, lim_ext;
   logic signed [X_W-1:0]     x_ff, x_in;
   logic signed [PIN_W-1:0]   cur_ff, cur_in;
   logic                      tag_last_ff, tag_last_in;
   out_width_type             ow_ff, ow_in;
   logic signed [SEG_W-1:0]   seg_ff, seg_in, seg_full;
   logic signed [SLOPE_W-1:0] slope_ff, slope_in;
   logic signed [SLOPE_W:0]   slope_ext;
   logic signed [CHUNK_W:0]   chunk;
   logic signed [PP_W-1:0]    pp_ff, pp_in;
   logic signed [ACC_W-1:0]   pp_ext, pp_shift;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic [VALUE_W-1:0]        int_part, int_masked;
   logic                      round_up;
   logic                      out_free;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]        rsp_value_ff, rsp_value_in;
   logic                      rsp_status_ff, rsp_status_in;
   logic                      rsp_last_ff, rsp_last_in;

   assign idx_wide = XW'(q_data.point_index);
   assign wr_addr  = idx_wide[AW-1:0];
   assign idx_p1   = {1'b0, idx_ff} + (CNT_W + 1)'(1);
   assign idx_p2   = {1'b0, idx_ff} + (CNT_W + 1)'(2);
   assign lim_ext  = {1'b0, point_limit};
   assign out_free = !rsp_valid_ff || rsp_ready;

   // table memories, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         in_tbl_ff[wr_addr]    <= q_data.point_in;
         out_tbl_ff[wr_addr]   <= q_data.point_out;
         slope_tbl_ff[wr_addr] <= q_data.point_slope;
      end
      in_q_ff    <= in_tbl_ff[rd_addr];
      out_q_ff   <= out_tbl_ff[rd_addr];
      slope_q_ff <= slope_tbl_ff[rd_addr];
   end

   // segment offset from the selected breakpoint
   assign seg_full = $signed({x_ff[X_W-1], x_ff}) - $signed({cur_ff[PIN_W-1], cur_ff});

   // partial product of the offset with one slice of the slope
   assign slope_ext = {slope_ff[SLOPE_W-1], slope_ff};
   always_comb begin
      case (step_ff)
         STEP_W'(0): chunk = {1'b0, slope_ext[CHUNK_W-1:0]};
         STEP_W'(1): chunk = {1'b0, slope_ext[2*CHUNK_W-1:CHUNK_W]};
         default:    chunk = {slope_ext[SLOPE_W], slope_ext[SLOPE_W:2*CHUNK_W]};
      endcase
   end

   // align the partial product to its slice
   assign pp_ext = ACC_W'(pp_ff);
   always_comb begin
      case (step_ff)
         STEP_W'(0): pp_shift = pp_ext;
         STEP_W'(1): pp_shift = pp_ext <<< CHUNK_W;
         default:    pp_shift = pp_ext <<< (2 * CHUNK_W);
      endcase
   end

   // truncate toward zero and wrap to the output width
   assign round_up = acc_ff[ACC_W-1] && (acc_ff[FRAC_W-1:0] != '0);
   assign int_part = acc_ff[FRAC_W+VALUE_W-1:FRAC_W] + VALUE_W'(round_up);
   always_comb begin
      case (ow_ff)
         OW_32:   int_masked = int_part;
         OW_16:   int_masked = {16'd0, int_part[15:0]};
         default: int_masked = {24'd0, int_part[7:0]};
      endcase
   end

   // sequencer: table writes, reject words, breakpoint scan, multiply-accumulate, result
   always_comb begin
      state_in      = state_ff;
      q_ready       = 1'b0;
      wr_en         = 1'b0;
      rd_addr       = idx_ff[AW-1:0];
      idx_in        = idx_ff;
      x_in          = x_ff;
      cur_in        = cur_ff;
      tag_last_in   = tag_last_ff;
      ow_in         = ow_ff;
      seg_in        = seg_ff;
      slope_in      = slope_ff;
      pp_in         = pp_ff;
      acc_in        = acc_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               case (q_data.kind)
                  ITEM_LOAD: begin
                     q_ready = 1'b1;
                     wr_en   = 1'b1;
                  end
                  ITEM_CONVERT: begin
                     q_ready     = 1'b1;
                     x_in        = q_data.sample_x;
                     tag_last_in = q_data.last;
                     ow_in       = q_data.out_width;
                     idx_in      = '0;
                     rd_addr     = '0;
                     state_in    = BK_FIRST;
                  end
                  ITEM_REJECT: begin
                     if (out_free) begin
                        q_ready       = 1'b1;
                        rsp_valid_in  = 1'b1;
                        rsp_value_in  = '0;
                        rsp_status_in = 1'b1;
                        rsp_last_in   = q_data.last;
                     end
                  end
                  default: begin
                     q_ready = 1'b1;
                  end
               endcase
            end
         end
         BK_FIRST: begin
            cur_in = in_q_ff;
            if (idx_p1 < lim_ext) begin
               rd_addr  = idx_p1[AW-1:0];
               state_in = BK_SCAN;
            end else begin
               state_in = BK_FETCH;
            end
         end
         BK_SCAN: begin
            if ((x_ff > cur_ff) && (x_ff >= in_q_ff)) begin
               idx_in = idx_p1[CNT_W-1:0];
               cur_in = in_q_ff;
               if (idx_p2 < lim_ext) begin
                  rd_addr = idx_p2[AW-1:0];
               end else begin
                  rd_addr  = idx_p1[AW-1:0];
                  state_in = BK_FETCH;
               end
            end else begin
               state_in = BK_FETCH;
            end
         end
         BK_FETCH: begin
            seg_in   = (!seg_full[SEG_W-1] && (seg_full != '0)) ? seg_full : '0;
            slope_in = slope_q_ff;
            acc_in   = ACC_W'(out_q_ff);
            step_in  = '0;
            state_in = BK_MUL;
         end
         BK_MUL: begin
            pp_in    = seg_ff * chunk;
            state_in = BK_ADD;
         end
         BK_ADD: begin
            acc_in = acc_ff + pp_shift;
            if (step_ff == STEP_W'(CHUNK_N - 1)) begin
               state_in = BK_ROUND;
            end else begin
               step_in  = step_ff + STEP_W'(1);
               state_in = BK_MUL;
            end
         end
         BK_ROUND: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = int_masked;
               rsp_status_in = 1'b0;
               rsp_last_in   = tag_last_ff;
               state_in      = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      x_ff          <= x_in;
      cur_ff        <= cur_in;
      tag_last_ff   <= tag_last_in;
      ow_ff         <= ow_in;
      seg_ff        <= seg_in;
      slope_ff      <= slope_in;
      pp_ff         <= pp_in;
      acc_ff        <= acc_in;
      step_ff       <= step_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_last_out = rsp_last_ff;

   // checks
   `PLSR_ASSERT_IMPL(a_scan_in_range, clock, reset,
      state_ff == BK_SCAN, idx_p1 < lim_ext, "scan read past active points")
   `PLSR_ASSERT_IMPL(a_pop_only_idle, clock, reset,
      q_valid && q_ready, state_ff == BK_IDLE, "queue popped while busy")
   `PLSR_ASSERT_IMPL(a_step_range, clock, reset,
      state_ff == BK_ADD, step_ff <= STEP_W'(CHUNK_N - 1), "slope slice out of range")
   `PLSR_ASSERT_NEXT(a_round_delivers, clock, reset,
      state_ff == BK_ROUND && state_in == BK_IDLE, rsp_valid_ff && !rsp_status_ff,
      "converted word not presented")
   `PLSR_ASSERT_NEXT(a_reject_delivers, clock, reset,
      state_ff == BK_IDLE && q_valid && q_ready && q_data.kind == ITEM_REJECT,
      rsp_valid_ff && rsp_status_ff && rsp_value_ff == '0, "reject word not presented")

endmodule

FILE: sv/piecewise_linear_sample_remap_top.sv
`timescale 1ns / 1ps

// channel   ports                                  word
// req       req_valid / req_ready                  mode, point_*, sample, last_in
// rsp       rsp_valid / rsp_ready                  value, status, last_out
// csr       csr_we, csr_index, csr_wdata           point_count, input_type, output_type
//
// in the back end a load word is written into the tables; for a convert word the
// table is scanned one breakpoint per cycle through the single read port, then three 34x18
// partial products are accumulated
// the 2-word queue lets the front accept words while the back end works or while a
// finished word waits on rsp_ready; reset clears control only, tables are unset until loaded

module piecewise_linear_sample_remap_top import plsr_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_mode,
   input  logic [IDX_W-1:0]          req_point_index,
   input  logic signed [PIN_W-1:0]   req_point_in,
   input  logic signed [POUT_W-1:0]  req_point_out,
   input  logic signed [SLOPE_W-1:0] req_point_slope,
   input  logic [SAMPLE_W-1:0]       req_sample,
   input  logic                      req_last_in,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [VALUE_W-1:0]        rsp_value,
   output logic                      rsp_status,
   output logic                      rsp_last_out
);

   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   logic              push_valid;
   logic              push_ready;
   queue_entry_type   push_data;
   logic              pop_valid;
   logic              pop_ready;
   queue_entry_type   pop_data;
   logic [CNT_W-1:0]  point_limit;

   // configuration, decode and classification
   plsr_front #(
      .MAX_POINTS (MAX_POINTS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_point_index (req_point_index),
      .req_point_in    (req_point_in),
      .req_point_out   (req_point_out),
      .req_point_slope (req_point_slope),
      .req_sample      (req_sample),
      .req_last_in     (req_last_in),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_data       (push_data),
      .point_limit     (point_limit)
   );

   // decoupling queue
   plsr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // table, scan and interpolation
   plsr_back #(
      .MAX_POINTS (MAX_POINTS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .point_limit  (point_limit),
      .q_valid      (pop_valid),
      .q_ready      (pop_ready),
      .q_data       (pop_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_value    (rsp_value),
      .rsp_status   (rsp_status),
      .rsp_last_out (rsp_last_out)
   );

endmodule
